FILE: src/pqa_pkg.sv
// ----------------------------------------------------------------------------
// pqa_pkg
// Shared types and constants for the aging priority queue: field widths,
// status and action codes, and the control word sent to the cell row.
// ----------------------------------------------------------------------------
package pqa_pkg;

  // Default sizes of the queue.
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned ID_MAX_DEF   = 1023;
  localparam int unsigned PRIO_MAX_DEF = 255;

  // Fixed field widths.
  localparam int unsigned ID_W     = 10;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // Priorities at this value stop aging.
  localparam logic [PRIO_W-1:0] PRIO_FLOOR = PRIO_W'(1);

  // Kind of an input item.
  typedef enum logic {
    ACT_INSERT   = 1'b0,
    ACT_RETRIEVE = 1'b1
  } action_e;

  // Result status.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Operation applied to every cell at once.
  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_RETRIEVE = 2'd2
  } cell_op_e;

  // Control word broadcast along the cell row.
  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   new_id;
    logic [PRIO_W-1:0] new_prio;
  } pqa_ctrl_t;

endpackage

FILE: src/pqa_cell.sv
// ----------------------------------------------------------------------------
// pqa_cell
// One slot of the sorted queue. On an insert it keeps its entry, takes the
// new entry, or takes its left neighbor's entry; on a retrieve it takes its
// right neighbor's entry with the priority aged by one down to the floor.
// ----------------------------------------------------------------------------
module pqa_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                      clk_i,
  input  pqa_pkg::pqa_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic                      left_gt_i,
  input  logic [pqa_pkg::ID_W-1:0]   left_id_i,
  input  logic [pqa_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [pqa_pkg::ID_W-1:0]   right_id_i,
  input  logic [pqa_pkg::PRIO_W-1:0] right_prio_i,
  output logic [pqa_pkg::ID_W-1:0]   id_o,
  output logic [pqa_pkg::PRIO_W-1:0] prio_o,
  output logic                      gt_o
);

  logic [pqa_pkg::ID_W-1:0]   id_q, id_d;
  logic [pqa_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic                       occupied;
  logic                       at_tail;

  // Slot occupancy follows from the entry count.
  assign occupied = CNT_W'(CELL_IDX) < count_i;
  assign at_tail  = CNT_W'(CELL_IDX) == count_i;

  // The new entry goes behind every entry with an equal or smaller priority.
  assign gt_o = occupied && (prio_q > ctrl_i.new_prio);

  // Next slot contents.
  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    unique case (ctrl_i.op)
      pqa_pkg::OP_INSERT: begin
        if (left_gt_i) begin
          id_d   = left_id_i;
          prio_d = left_prio_i;
        end else if (gt_o || at_tail) begin
          id_d   = ctrl_i.new_id;
          prio_d = ctrl_i.new_prio;
        end
      end
      pqa_pkg::OP_RETRIEVE: begin
        id_d   = right_id_i;
        prio_d = (right_prio_i > pqa_pkg::PRIO_FLOOR) ?
                 right_prio_i - pqa_pkg::PRIO_FLOOR : right_prio_i;
      end
      default: begin
        id_d   = id_q;
        prio_d = prio_q;
      end
    endcase
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

FILE: src/priority_queue_with_aging.sv
// ----------------------------------------------------------------------------
// priority_queue_with_aging
// Bounded priority queue kept sorted in a row of cells, smallest priority
// first, with aging of the remaining entries on every retrieve.
// ----------------------------------------------------------------------------
// The queue takes one item per clock cycle and gives its result from an
// output register in the cycle after it takes the item; the only stall is
// that register still holding an untaken result. The row of DEPTH cells
// compares, shifts and ages all entries at once, each cell exchanging its
// entry with its neighbors. Entries with equal priority leave in arrival
// order. A bad id or priority, an insert into a full queue and a retrieve
// from an empty queue return a status and leave the queue unchanged. Slot
// contents need no clearing after reset.
module priority_queue_with_aging #(
  parameter int unsigned DEPTH    = pqa_pkg::DEPTH_DEF,
  parameter int unsigned ID_MAX   = pqa_pkg::ID_MAX_DEF,
  parameter int unsigned PRIO_MAX = pqa_pkg::PRIO_MAX_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned IN_BITS   = pqa_pkg::ID_W + pqa_pkg::PRIO_W,
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS  = pqa_pkg::ID_W + CNT_W,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_id [9:0], entry_priority [17:10], zero fill above
  input  logic [IN_W-1:0]              s_axis_tdata,
  // action
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_id [9:0], occupancy above it, zero fill above
  output logic [OUT_W-1:0]             m_axis_tdata,
  // status
  output logic [pqa_pkg::STATUS_W-1:0] m_axis_tuser
);

  logic                       accept;
  logic [pqa_pkg::ID_W-1:0]   in_id;
  logic [pqa_pkg::PRIO_W-1:0] in_prio;
  logic                       is_retrieve;
  logic [CNT_W-1:0]           count_q, count_d;
  pqa_pkg::status_e           status;
  pqa_pkg::pqa_ctrl_t         ctrl;
  logic [pqa_pkg::ID_W-1:0]   front_id;

  logic [pqa_pkg::ID_W-1:0]   cell_id   [DEPTH];
  logic [pqa_pkg::PRIO_W-1:0] cell_prio [DEPTH];
  logic                       cell_gt   [DEPTH];

  logic                       out_valid_q;
  logic [pqa_pkg::ID_W-1:0]   out_id_q;
  pqa_pkg::status_e           out_status_q;
  logic [CNT_W-1:0]           out_occ_q;

  // Input unpacking and handshake.
  assign in_id         = s_axis_tdata[pqa_pkg::ID_W-1:0];
  assign in_prio       = s_axis_tdata[IN_BITS-1:pqa_pkg::ID_W];
  assign is_retrieve   = s_axis_tuser == pqa_pkg::ACT_RETRIEVE;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Status of the offered item; checks on an insert go validity first.
  always_comb begin
    if (is_retrieve) begin
      status = (count_q == '0) ? pqa_pkg::ST_EMPTY : pqa_pkg::ST_OK;
    end else if ((32'(in_id) > 32'(ID_MAX)) || (in_prio == '0) ||
                 (32'(in_prio) > 32'(PRIO_MAX))) begin
      status = pqa_pkg::ST_INVALID;
    end else if (count_q == CNT_W'(DEPTH)) begin
      status = pqa_pkg::ST_FULL;
    end else begin
      status = pqa_pkg::ST_OK;
    end
  end

  // Control word for the cell row and the next entry count.
  always_comb begin
    ctrl.op       = pqa_pkg::OP_HOLD;
    ctrl.new_id   = in_id;
    ctrl.new_prio = in_prio;
    count_d       = count_q;
    if (accept && (status == pqa_pkg::ST_OK)) begin
      if (is_retrieve) begin
        ctrl.op = pqa_pkg::OP_RETRIEVE;
        count_d = count_q - CNT_W'(1);
      end else begin
        ctrl.op = pqa_pkg::OP_INSERT;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Row of cells, front entry in cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       left_gt;
    logic [pqa_pkg::ID_W-1:0]   left_id, right_id;
    logic [pqa_pkg::PRIO_W-1:0] left_prio, right_prio;

    if (i == 0) begin : g_first
      assign left_gt   = 1'b0;
      assign left_id   = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_gt   = cell_gt[i-1];
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    pqa_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_gt_i    (left_gt),
      .left_id_i    (left_id),
      .left_prio_i  (left_prio),
      .right_id_i   (right_id),
      .right_prio_i (right_prio),
      .id_o         (cell_id[i]),
      .prio_o       (cell_prio[i]),
      .gt_o         (cell_gt[i])
    );
  end

  assign front_id = cell_id[0];

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_id_q     <= (is_retrieve && (status == pqa_pkg::ST_OK)) ? front_id : '0;
      out_status_q <= status;
      out_occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_W'({out_occ_q, out_id_q});

  // The entry count never passes the number of cells.
  a_count_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)
  ) else $error("entry count above queue depth");

  // A retrieve from an empty queue reports empty with a zero id.
  a_empty_retrieve : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && is_retrieve && (count_q == '0)) |=>
      (m_axis_tuser == pqa_pkg::ST_EMPTY) && (out_id_q == '0)
  ) else $error("empty retrieve not reported");

  // A good retrieve removes exactly one entry.
  a_retrieve_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && is_retrieve && (count_q != '0)) |=>
      (count_q == $past(count_q) - CNT_W'(1))
  ) else $error("retrieve did not remove one entry");

  // The reported occupancy follows the entry count.
  a_occ_match : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_occ_q == count_q)
  ) else $error("occupancy differs from entry count");

endmodule

FILE: tb/priority_queue_with_aging_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_queue_with_aging_test
// Self-checking bench for the aging priority queue. It keeps its own model of
// the sorted entry row and predicts id, status and occupancy for every
// accepted item. Each result is checked against that prediction. A short
// directed part covers the empty, full and invalid cases, ties and the aging
// floor. Random traffic follows in phases that fill and drain the queue, with
// random gaps on both stream sides.
// ----------------------------------------------------------------------------
module priority_queue_with_aging_test;

  localparam int unsigned DEPTH    = pqa_pkg::DEPTH_DEF;
  localparam int unsigned ID_MAX   = pqa_pkg::ID_MAX_DEF;
  localparam int unsigned PRIO_MAX = pqa_pkg::PRIO_MAX_DEF;
  localparam int unsigned ID_W     = pqa_pkg::ID_W;
  localparam int unsigned PRIO_W   = pqa_pkg::PRIO_W;
  localparam int unsigned STATUS_W = pqa_pkg::STATUS_W;
  localparam int unsigned OCC_W    = $clog2(DEPTH + 1);
  localparam int unsigned IN_W     = (((ID_W + PRIO_W) + 7) / 8) * 8;
  localparam int unsigned OUT_W    = (((ID_W + OCC_W) + 7) / 8) * 8;
  localparam int unsigned N_RANDOM = 1430;

  // One predicted result of the queue.
  typedef struct {
    logic [ID_W-1:0]  id;
    pqa_pkg::status_e status;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata  = '0;
  logic                s_tuser  = pqa_pkg::ACT_INSERT;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // Model of the entry row, front at index zero.
  logic [ID_W-1:0]   model_ids   [DEPTH];
  logic [PRIO_W-1:0] model_prios [DEPTH];
  int unsigned       model_count = 0;

  queue_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  bit            idle_off = 1'b0;
  int unsigned   stall_left = 0;

  priority_queue_with_aging dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one operation to the model and return what the queue must answer.
  function automatic queue_result_t apply_queue_op(input pqa_pkg::action_e act,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int unsigned   pos;
    res.id     = '0;
    res.status = pqa_pkg::ST_OK;
    if (act == pqa_pkg::ACT_INSERT) begin
      if (id > ID_MAX || prio == '0 || prio > PRIO_MAX) begin
        res.status = pqa_pkg::ST_INVALID;
      end else if (model_count >= DEPTH) begin
        res.status = pqa_pkg::ST_FULL;
      end else begin
        // Walk back past every entry with a larger value.
        pos = model_count;
        while (pos > 0 && model_prios[pos-1] > prio) begin
          model_ids[pos]   = model_ids[pos-1];
          model_prios[pos] = model_prios[pos-1];
          pos--;
        end
        model_ids[pos]   = id;
        model_prios[pos] = prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = pqa_pkg::ST_EMPTY;
      end else begin
        // Pop the front and age the rest down to the floor.
        res.id = model_ids[0];
        for (int unsigned i = 1; i < model_count; i++) begin
          model_ids[i-1]   = model_ids[i];
          model_prios[i-1] = (model_prios[i] > pqa_pkg::PRIO_FLOOR) ?
                             model_prios[i] - 1'b1 : model_prios[i];
        end
        model_count--;
      end
    end
    res.occupancy = OCC_W'(model_count);
    return res;
  endfunction

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(input pqa_pkg::action_e act, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_W - ID_W - PRIO_W){1'b0}}, prio, id};
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(apply_queue_op(act, id, prio));
  endtask

  // Receiver side: random stalls, no new ones while idling is switched off.
  always @(negedge clk_i) begin : drive_ready
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!idle_off && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // Compare every taken result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", m_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[ID_W-1:0] !== want.id)
          report_mismatch("out_id", m_tdata[ID_W-1:0], want.id);
        if (m_tuser !== want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[ID_W +: OCC_W] !== want.occupancy)
          report_mismatch("occupancy", m_tdata[ID_W +: OCC_W], want.occupancy);
      end
    end
  end

  // Retrieve from the empty queue and insert with priority zero.
  task automatic test_empty_and_invalid();
    send_item(pqa_pkg::ACT_RETRIEVE, 10'h3FF, 8'hFF);
    send_item(pqa_pkg::ACT_INSERT, 10'd5, 8'd0);
  endtask

  // Fill to capacity with extreme fields and ties, then push past the top.
  task automatic test_fill_and_overflow();
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      id   = ID_W'($urandom_range(0, ID_MAX));
      prio = PRIO_W'($urandom_range(2, PRIO_MAX - 1));
      case (i)
        0: begin
          id   = '0;
          prio = PRIO_W'(PRIO_MAX);
        end
        1: begin
          id   = ID_W'(ID_MAX);
          prio = pqa_pkg::PRIO_FLOOR;
        end
        2, 3, 4: begin
          id   = ID_W'(100 + i);
          prio = 8'd5;
        end
        5, 6: begin
          id   = ID_W'(200 + i);
          prio = pqa_pkg::PRIO_FLOOR;
        end
        7: prio = 8'd2;
        default: ;
      endcase
      send_item(pqa_pkg::ACT_INSERT, id, prio);
    end
    send_item(pqa_pkg::ACT_INSERT, 10'd77, 8'd9);
    // A bad priority is reported as invalid even when full.
    send_item(pqa_pkg::ACT_INSERT, 10'h3FF, 8'd0);
  endtask

  // Two retrieves age the rest; entries at the floor stay there.
  task automatic test_aging_on_retrieve();
    send_item(pqa_pkg::ACT_RETRIEVE, '0, '0);
    send_item(pqa_pkg::ACT_RETRIEVE, 10'h2AA, 8'h55);
  endtask

  // Random traffic in phases that lean toward filling, draining or neither.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       phase_len;
    int unsigned       insert_pct;
    int unsigned       r;
    logic [PRIO_W-1:0] prio;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      idle_off = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 0; k < phase_len && sent < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5)       prio = '0;
        else if (r < 35) prio = PRIO_W'($urandom_range(1, 4));
        else if (r < 40) prio = PRIO_W'(PRIO_MAX);
        else             prio = PRIO_W'($urandom_range(1, PRIO_MAX));
        if ($urandom_range(0, 99) < insert_pct)
          send_item(pqa_pkg::ACT_INSERT, ID_W'($urandom_range(0, ID_MAX)), prio);
        else
          send_item(pqa_pkg::ACT_RETRIEVE, ID_W'($urandom_range(0, ID_MAX)), prio);
        sent++;
      end
    end
    idle_off = 1'b0;
  endtask

  // Main sequence.
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_and_invalid();
    test_fill_and_overflow();
    test_aging_on_retrieve();
    test_random_traffic(N_RANDOM);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
src/pqa_pkg.sv
src/pqa_cell.sv
src/priority_queue_with_aging.sv
tb/priority_queue_with_aging_test.sv
